// ----- src/smr_pkg.sv -----
// Shared types and constants for the square matrix rotator.
package smr_pkg;

    localparam int ELEM_W    = 32;
    localparam int SIDE_W    = 4;
    localparam int PROD_W    = 2 * SIDE_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd1;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 4'd8;

    // Emission order for one loaded bank
    typedef struct packed {
        logic              bank;
        logic [SIDE_W-1:0] side;
        logic              dir;
    } t_cmd;

    // Back end hands a bank back to the loader
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    typedef struct packed {
        logic running;
        logic bank;
    } t_back_status;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

// ----- src/smr_if.sv -----
// Handshake channel interfaces: element in, rotated element out, register writes.
interface smr_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [smr_pkg::ELEM_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface smr_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [smr_pkg::ELEM_W-1:0] rotated_element;
    logic                            last;

    modport source (output valid, output rotated_element, output last, input ready);
    modport sink   (input valid, input rotated_element, input last, output ready);
endinterface

interface smr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [smr_pkg::CFG_IDX_W-1:0]     index;
    logic [smr_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/smr_ram.sv -----
// Generic simple dual-port RAM with registered read.
module smr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/smr_cmd_queue.sv -----
// Two-entry queue of emission orders between loader and emitter.
module smr_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output smr_pkg::t_cmd o_cmd
);

    smr_pkg::t_cmd r_mem [2];
    logic          r_wptr, n_wptr;
    logic          r_rptr, n_rptr;
    logic [1:0]    r_count, n_count;
    logic          w_push, w_pop;

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = w_push ? !r_wptr : r_wptr;
        n_rptr  = w_pop ? !r_rptr : r_rptr;
        n_count = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_cmd   = r_mem[r_rptr];

endmodule

// ----- src/smr_front.sv -----
// Loader: takes elements into the free bank and queues a rotation when full.
module smr_front #(
    parameter int MAX_SIDE = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    smr_in_if.sink                      i_elem,
    input  logic [smr_pkg::SIDE_W-1:0]  i_side,
    input  logic                        i_dir,
    input  logic                        i_q_full,
    input  smr_pkg::t_release           i_release,
    output logic                        o_push,
    output smr_pkg::t_cmd               o_cmd,
    output logic                        o_wr_en,
    output logic [$clog2(2*MAX_SIDE*MAX_SIDE)-1:0] o_wr_addr,
    output logic [smr_pkg::ELEM_W-1:0]  o_wr_data
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(2 * DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [CNTW-1:0]             r_count, n_count;
    logic                        r_bank, n_bank;
    logic [1:0]                  r_busy, n_busy;
    logic [smr_pkg::SIDE_W-1:0]  w_n;
    logic [smr_pkg::PROD_W-1:0]  w_total;
    logic [CNTW-1:0]             w_count_inc;
    logic                        w_accept, w_done;

    always_comb begin
        if (i_side == '0) begin
            w_n = smr_pkg::SIDE_W'(1);
        end else if (i_side > smr_pkg::SIDE_W'(MAX_SIDE)) begin
            w_n = smr_pkg::SIDE_W'(MAX_SIDE);
        end else begin
            w_n = i_side;
        end
    end

    assign w_total     = {{smr_pkg::SIDE_W{1'b0}}, w_n} * {{smr_pkg::SIDE_W{1'b0}}, w_n};
    assign i_elem.ready = !r_busy[r_bank] && !i_q_full;
    assign w_accept    = i_elem.valid && i_elem.ready;
    assign w_count_inc = r_count + 1'b1;
    assign w_done      = w_accept &&
                         ({{(smr_pkg::PROD_W-CNTW){1'b0}}, w_count_inc} >= w_total);

    always_comb begin
        n_count = r_count;
        n_bank  = r_bank;
        n_busy  = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (w_accept) begin
            n_count = w_count_inc;
        end
        if (w_done) begin
            n_count        = '0;
            n_bank         = !r_bank;
            n_busy[r_bank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            r_count <= n_count;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

    // bank 1 starts right after bank 0
    assign o_push      = w_done;
    assign o_cmd.bank  = r_bank;
    assign o_cmd.side  = w_n;
    assign o_cmd.dir   = i_dir;
    assign o_wr_en     = w_accept;
    assign o_wr_addr   = r_bank ? (AW'(DEPTH) + AW'(r_count)) : AW'(r_count);
    assign o_wr_data   = i_elem.element;

endmodule

// ----- src/smr_back.sv -----
// Emitter: walks the rotated order of a loaded bank and drives the output word.
module smr_back #(
    parameter int MAX_SIDE = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  smr_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output smr_pkg::t_release           o_release,
    output smr_pkg::t_back_status       o_status,
    output logic                        o_rd_en,
    output logic [$clog2(2*MAX_SIDE*MAX_SIDE)-1:0] o_rd_addr,
    input  logic [smr_pkg::ELEM_W-1:0]  i_rd_data,
    smr_out_if.source                   o_rot
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(2 * DEPTH);
    localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    smr_pkg::t_back_state        r_state, n_state;
    logic [CW-1:0]               r_r, r_c;
    logic [smr_pkg::SIDE_W-1:0]  r_n;
    logic                        r_dir, r_bank;
    logic                        r_pend, r_pend_last;
    logic                        r_ovalid, r_olast;
    logic [smr_pkg::ELEM_W-1:0]  r_odata;
    logic                        w_issue, w_last_issue, w_pop;
    logic [smr_pkg::SIDE_W-1:0]  w_r, w_c, w_nm1, w_row, w_col;
    logic [smr_pkg::PROD_W-1:0]  w_src;

    assign w_r   = smr_pkg::SIDE_W'(r_r);
    assign w_c   = smr_pkg::SIDE_W'(r_c);
    assign w_nm1 = r_n - 1'b1;

    // cw: in[n-1-c][r], ccw: in[c][n-1-r]
    always_comb begin
        w_row = r_dir ? w_c : (w_nm1 - w_c);
        w_col = r_dir ? (w_nm1 - w_r) : w_r;
        w_src = {{smr_pkg::SIDE_W{1'b0}}, w_row} * {{smr_pkg::SIDE_W{1'b0}}, r_n}
              + {{smr_pkg::SIDE_W{1'b0}}, w_col};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            smr_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = smr_pkg::BK_RUN;
                end
            end
            smr_pkg::BK_RUN: begin
                if (w_last_issue) begin
                    n_state = smr_pkg::BK_IDLE;
                end
            end
            default: n_state = smr_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        w_pop   = 1'b0;
        w_issue = 1'b0;
        case (r_state)
            smr_pkg::BK_IDLE: begin
                w_pop = i_q_valid;
            end
            smr_pkg::BK_RUN: begin
                w_issue = !r_pend && (!r_ovalid || o_rot.ready);
            end
            default: begin
                w_pop   = 1'b0;
                w_issue = 1'b0;
            end
        endcase
        w_last_issue = w_issue && (w_r == w_nm1) && (w_c == w_nm1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smr_pkg::BK_IDLE;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= w_issue;
            r_pend_last <= w_last_issue;
            if (r_pend) begin
                r_ovalid <= 1'b1;
            end else if (o_rot.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_n    <= i_cmd.side;
            r_dir  <= i_cmd.dir;
            r_bank <= i_cmd.bank;
            r_r    <= '0;
            r_c    <= '0;
        end else if (w_issue) begin
            if (w_c == w_nm1) begin
                r_c <= '0;
                r_r <= r_r + 1'b1;
            end else begin
                r_c <= r_c + 1'b1;
            end
        end
        if (r_pend) begin
            r_odata <= i_rd_data;
            r_olast <= r_pend_last;
        end
    end

    assign o_pop            = w_pop;
    assign o_release.valid  = w_last_issue;
    assign o_release.bank   = r_bank;
    assign o_status.running = (r_state == smr_pkg::BK_RUN);
    assign o_status.bank    = r_bank;
    assign o_rd_en          = w_issue;
    assign o_rd_addr        = r_bank ? (AW'(DEPTH) + AW'(w_src)) : AW'(w_src);

    assign o_rot.valid           = r_ovalid;
    assign o_rot.rotated_element = r_odata;
    assign o_rot.last            = r_olast;

endmodule

// ----- src/square_matrix_rotate_90.sv -----
// Top level of the 90-degree square matrix rotator.
//
// Usage: write side (index 0) and direction (index 1, 0 = clockwise) on i_cfg
// while idle; i_cfg.ready is always high. Send elements in row-major order on
// i_elem, one per word. After side*side elements the rotated matrix leaves on
// o_rot in row-major order, with last set on its final word.
// Two banks of element memory: one matrix loads while the previous one drains.
// The loader writes each accepted element into the free bank as it arrives. The
// emitter issues one memory read per element and waits for its registered data
// before it issues the next read.
// Reset (synchronous, active low) empties both banks and the order queue and
// sets side to 8, direction to clockwise. Memory contents are not cleared.
// When o_rot stalls the output word holds and reads pause; i_elem keeps
// accepting until both banks hold matrices waiting to drain.
module square_matrix_rotate_90 #(
    parameter int MAX_SIDE = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smr_in_if.sink    i_elem,
    smr_cfg_if.sink   i_cfg,
    smr_out_if.source o_rot
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(2 * DEPTH);

    logic [smr_pkg::SIDE_W-1:0] r_side;
    logic                       r_dir;

    logic                       w_push, w_pop, w_q_valid, w_q_full;
    smr_pkg::t_cmd              w_cmd_in, w_cmd_out;
    smr_pkg::t_release          w_release;
    smr_pkg::t_back_status      w_status;
    logic                       w_wr_en, w_rd_en;
    logic [AW-1:0]              w_wr_addr, w_rd_addr;
    logic [smr_pkg::ELEM_W-1:0] w_wr_data, w_rd_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= smr_pkg::SIDE_RESET;
            r_dir  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                smr_pkg::REG_SIDE:      r_side <= i_cfg.data;
                smr_pkg::REG_DIRECTION: r_dir  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    smr_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_elem    (i_elem),
        .i_side    (r_side),
        .i_dir     (r_dir),
        .i_q_full  (w_q_full),
        .i_release (w_release),
        .o_push    (w_push),
        .o_cmd     (w_cmd_in),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    smr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_cmd   (w_cmd_out)
    );

    smr_ram #(.WIDTH(smr_pkg::ELEM_W), .DEPTH(2 * DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    smr_back #(.MAX_SIDE(MAX_SIDE)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_cmd     (w_cmd_out),
        .o_pop     (w_pop),
        .o_release (w_release),
        .o_status  (w_status),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_rot     (o_rot)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("order queue overflow");

    a_bank_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && w_status.running) |-> ((w_wr_addr >= AW'(DEPTH)) != w_status.bank))
        else $error("loader writing the bank being drained");

    a_release_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_release.valid |-> (w_status.running && w_rd_en))
        else $error("bank released outside a drain");

    a_pop_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> w_status.running)
        else $error("drain did not start after taking an order");

endmodule

// ----- test/smr_rotation_checker.sv -----
// Predictor and scoreboard that watch the rotator's channels and count mismatches.
`timescale 1ns / 100ps

package smr_tb_pkg;

    typedef enum logic {
        TURN_CW  = 1'b0,
        TURN_CCW = 1'b1
    } t_turn;

endpackage

module smr_rotation_checker #(
    parameter int MAX_SIDE = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    smr_in_if    i_elem,
    smr_cfg_if   i_cfg,
    smr_out_if   i_rot,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_words_in,
    output int   o_words_out,
    output int   o_matrices
);

    typedef struct {
        logic signed [smr_pkg::ELEM_W-1:0] value;
        logic                              last;
    } t_rot_word;

    logic signed [smr_pkg::ELEM_W-1:0] matrix_store [MAX_SIDE*MAX_SIDE];
    logic [smr_pkg::SIDE_W-1:0]        side_reg;
    smr_tb_pkg::t_turn                 turn_reg;
    int unsigned                       loaded;
    t_rot_word                         rotated_q [$];
    int                                fails = 0;
    int                                words_in = 0;
    int                                words_out = 0;
    int                                matrices = 0;

    function automatic int unsigned side_of(input logic [smr_pkg::SIDE_W-1:0] code);
        if (code == '0)
            return 1;
        if (code > MAX_SIDE)
            return MAX_SIDE;
        return code;
    endfunction

    task automatic load_element(input logic signed [smr_pkg::ELEM_W-1:0] value);
        int unsigned n;
        int unsigned src;
        t_rot_word   w;
        n = side_of(side_reg);
        if (loaded < MAX_SIDE * MAX_SIDE) begin
            matrix_store[loaded] = value;
            loaded++;
        end
        if (loaded >= n * n) begin
            for (int unsigned r = 0; r < n; r++) begin
                for (int unsigned c = 0; c < n; c++) begin
                    if (turn_reg == smr_tb_pkg::TURN_CW)
                        src = (n - 1 - c) * n + r;
                    else
                        src = c * n + (n - 1 - r);
                    w.value = matrix_store[src];
                    w.last  = (r == n - 1) && (c == n - 1);
                    rotated_q.push_back(w);
                end
            end
            loaded = 0;
            matrices++;
        end
    endtask

    task automatic check_word(input logic signed [smr_pkg::ELEM_W-1:0] value,
                              input logic last);
        t_rot_word w;
        words_out++;
        if (rotated_q.size() == 0) begin
            fails++;
            $error("unexpected word: rotated_element=%0d last=%0b", value, last);
        end else begin
            w = rotated_q.pop_front();
            if (value !== w.value) begin
                fails++;
                $error("rotated_element: expected %0d, got %0d", w.value, value);
            end
            if (last !== w.last) begin
                fails++;
                $error("last: expected %0b, got %0b", w.last, last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            side_reg = smr_pkg::SIDE_RESET;
            turn_reg = smr_tb_pkg::TURN_CW;
            loaded   = 0;
            rotated_q.delete();
        end else begin
            // drain before load, so a word is never matched against its own matrix
            if (i_rot.valid && i_rot.ready)
                check_word(i_rot.rotated_element, i_rot.last);
            if (i_elem.valid && i_elem.ready) begin
                words_in++;
                load_element(i_elem.element);
            end
            // a register write takes effect after this edge's element
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    smr_pkg::REG_SIDE:
                        side_reg = i_cfg.data[smr_pkg::SIDE_W-1:0];
                    smr_pkg::REG_DIRECTION:
                        turn_reg = smr_tb_pkg::t_turn'(i_cfg.data[0]);
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= rotated_q.size();
        o_words_in   <= words_in;
        o_words_out  <= words_out;
        o_matrices   <= matrices;
    end

endmodule

// ----- test/tb_square_matrix_rotate_90.sv -----
// Top of the rotator testbench: clock, reset, stimulus, handshake idling and verdict.
`timescale 1ns / 100ps

module tb_square_matrix_rotate_90;

    localparam int MAX_SIDE      = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;

    typedef enum int {
        MODE_FREE,
        MODE_SEND_IDLE,
        MODE_RECV_STALL,
        MODE_BOTH
    } t_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    int fail_count;
    int pending_words;
    int words_in;
    int words_out;
    int matrices;

    smr_in_if  elem_ch ();
    smr_cfg_if cfg_ch ();
    smr_out_if rot_ch ();

    square_matrix_rotate_90 #(
        .MAX_SIDE(MAX_SIDE)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_elem (elem_ch),
        .i_cfg  (cfg_ch),
        .o_rot  (rot_ch)
    );

    smr_rotation_checker #(
        .MAX_SIDE(MAX_SIDE)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_elem      (elem_ch),
        .i_cfg       (cfg_ch),
        .i_rot       (rot_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending_words),
        .o_words_in  (words_in),
        .o_words_out (words_out),
        .o_matrices  (matrices)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void set_mode(input t_mode mode);
        case (mode)
            MODE_FREE:       begin send_idle_pct = 0;  stall_pct = 0;  end
            MODE_SEND_IDLE:  begin send_idle_pct = 70; stall_pct = 0;  end
            MODE_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 70; end
            default:         begin send_idle_pct = 38; stall_pct = 38; end
        endcase
    endfunction

    function automatic logic signed [smr_pkg::ELEM_W-1:0] rand_element();
        case ($urandom_range(7))
            0:       return {1'b1, {(smr_pkg::ELEM_W-1){1'b0}}};
            1:       return {1'b0, {(smr_pkg::ELEM_W-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_word(input logic signed [smr_pkg::ELEM_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            elem_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        elem_ch.valid   <= 1'b1;
        elem_ch.element <= value;
        do @(posedge i_clk); while (!elem_ch.ready);
    endtask

    // drop valid, wait out every pending word and the pipeline tail
    task automatic settle();
        elem_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [smr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [smr_pkg::CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic apply_settings(input logic [smr_pkg::SIDE_W-1:0] side_code,
                                  input smr_tb_pkg::t_turn turn);
        logic [2:0] pad;
        pad = 3'($urandom_range(7));
        settle();
        write_reg(smr_pkg::REG_SIDE, side_code);
        write_reg(smr_pkg::REG_DIRECTION, {pad, turn});
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        rot_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rot_ch.ready <= 1'b0;
            end else begin
                rot_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((elem_ch.valid && elem_ch.ready) || (rot_ch.valid && rot_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        elem_ch.valid   <= 1'b0;
        elem_ch.element <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= smr_pkg::REG_SIDE;
        cfg_ch.data     <= '0;
        set_mode(MODE_FREE);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: side 8, clockwise
        push_word({1'b1, {(smr_pkg::ELEM_W-1){1'b0}}});
        push_word({1'b0, {(smr_pkg::ELEM_W-1){1'b1}}});
        push_word('0);
        push_word('1);
        push_word(32'shaaaa_aaaa);
        push_word(32'sh5555_5555);
        repeat (MAX_SIDE * MAX_SIDE - 6) push_word(rand_element());

        // one-element matrices; side zero behaves as side one
        set_mode(MODE_SEND_IDLE);
        apply_settings(4'd1, smr_tb_pkg::TURN_CW);
        push_word({1'b1, {(smr_pkg::ELEM_W-1){1'b0}}});
        apply_settings(4'd0, smr_tb_pkg::TURN_CCW);
        push_word('1);

        set_mode(MODE_RECV_STALL);
        apply_settings(4'd2, smr_tb_pkg::TURN_CCW);
        push_word({1'b1, {(smr_pkg::ELEM_W-1){1'b0}}});
        push_word({1'b0, {(smr_pkg::ELEM_W-1){1'b1}}});
        push_word(32'shaaaa_aaaa);
        push_word(32'sh5555_5555);
        apply_settings(4'd3, smr_tb_pkg::TURN_CW);
        for (int k = 1; k <= 9; k++)
            push_word(smr_pkg::ELEM_W'(k * 7 - 30));

        // side codes above the largest side saturate to it
        set_mode(MODE_BOTH);
        apply_settings(smr_pkg::SIDE_W'($urandom_range(9, 15)),
                       smr_tb_pkg::t_turn'($urandom_range(1)));
        repeat (MAX_SIDE * MAX_SIDE) push_word(rand_element());

        // long output hold-off: both banks fill and the input backs up
        set_mode(MODE_FREE);
        apply_settings(4'd1, smr_tb_pkg::t_turn'($urandom_range(1)));
        hold_req = 1'b1;
        repeat (4) push_word(rand_element());

        settle();
        $display("Rotated %0d matrices, %0d words in and %0d out: reset, unit, zero,",
                 matrices, words_in, words_out);
        $display("small and saturated sides, both turns, idling, stalls and a long hold-off.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
